@@ rtl/fcl_pkg.sv @@
package fcl_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 13;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_W     = 12;
  localparam int unsigned BPS_W    = 13;
  localparam int unsigned SPC_W    = 8;
  localparam int unsigned DSS_W    = 16;
  localparam int unsigned ENTRY_W  = 12;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // intermediate widths of the offset arithmetic
  localparam int unsigned PROD1_W  = ID_W + SPC_W;
  localparam int unsigned SECTOR_W = PROD1_W + 1;
  localparam int unsigned PROD2_W  = SECTOR_W + BPS_W;

  // odd entries sit in the upper 12 bits of the byte pair
  localparam int unsigned ODD_SHIFT = 4;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_SPAN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_START_SECTOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER        = 2'd3;

  // configuration reset values
  localparam logic [BPS_W-1:0]   BPS_RESET = 13'd512;
  localparam logic [SPC_W-1:0]   SPC_RESET = 8'd1;
  localparam logic [DSS_W-1:0]   DSS_RESET = 16'd33;
  localparam logic [ENTRY_W-1:0] END_RESET = 12'hFFF;

  // first cluster id that maps to the data region
  localparam logic [ID_W-1:0] FIRST_DATA_ID = 12'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_LO,
    ST_READ_HI,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic tbl_write;
    logic lookup_start;
    logic lo_capture;
    logic hi_capture;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/fcl_ctrl.sv @@
module fcl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             kind,
  output logic             in_stall,
  input  fcl_pkg::status_t status,
  output fcl_pkg::cmd_t    cmd
);

  fcl_pkg::state_t state;
  fcl_pkg::state_t state_next;
  logic            accept;

  assign accept = in_valid && !in_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fcl_pkg::ST_IDLE: begin
        if (accept && kind == fcl_pkg::KIND_LOOKUP) begin
          state_next = fcl_pkg::ST_READ_LO;
        end
      end
      fcl_pkg::ST_READ_LO: state_next = fcl_pkg::ST_READ_HI;
      fcl_pkg::ST_READ_HI: state_next = fcl_pkg::ST_RESULT;
      fcl_pkg::ST_RESULT: begin
        if (status.out_free) begin
          state_next = fcl_pkg::ST_IDLE;
        end
      end
      default: state_next = fcl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall         = 1'b1;
    cmd              = '0;
    case (state)
      fcl_pkg::ST_IDLE: begin
        in_stall         = 1'b0;
        cmd.tbl_write    = accept && kind == fcl_pkg::KIND_WRITE;
        cmd.lookup_start = accept && kind == fcl_pkg::KIND_LOOKUP;
      end
      fcl_pkg::ST_READ_LO: cmd.lo_capture = 1'b1;
      fcl_pkg::ST_READ_HI: cmd.hi_capture = 1'b1;
      fcl_pkg::ST_RESULT:  cmd.out_load   = status.out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

@@ rtl/fcl_datapath.sv @@
module fcl_datapath #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]      cfg_data,
  // request payload
  input  logic [fcl_pkg::ADDR_W-1:0]          table_address,
  input  logic [fcl_pkg::BYTE_W-1:0]          table_byte,
  input  logic [fcl_pkg::ID_W-1:0]            lookup_id,
  // control
  input  fcl_pkg::cmd_t                       cmd,
  output fcl_pkg::status_t                    status,
  // result
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fcl_pkg::ENTRY_W-1:0]         next_cluster,
  output logic                                chain_end,
  output logic                                bad_cluster,
  output logic [fcl_pkg::OFFSET_W-1:0]        device_byte_offset
);

  localparam int unsigned MemAw = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
  localparam int unsigned LimW  = fcl_pkg::ADDR_W + 1;
  localparam logic [LimW-1:0] TableLimit = LimW'(TABLE_BYTES);

  // configuration registers
  logic [fcl_pkg::BPS_W-1:0]   sector_size;
  logic [fcl_pkg::SPC_W-1:0]   cluster_span;
  logic [fcl_pkg::DSS_W-1:0]   data_start_sector;
  logic [fcl_pkg::ENTRY_W-1:0] end_marker;

  // table store and read port
  logic [fcl_pkg::BYTE_W-1:0] table_mem [0:TABLE_BYTES-1];
  logic [fcl_pkg::ADDR_W-1:0] rd_pos;
  logic                       rd_in_range;
  logic                       wr_in_range;
  logic [fcl_pkg::BYTE_W-1:0] rd_data;
  logic                       rd_valid;
  logic [fcl_pkg::BYTE_W-1:0] rd_byte;

  // lookup working registers
  logic [fcl_pkg::ID_W-1:0]     id_reg;
  logic [fcl_pkg::ADDR_W-1:0]   pos_reg;
  logic [fcl_pkg::ADDR_W-1:0]   pos_in;
  logic [fcl_pkg::ID_W-1:0]     id_m2;
  logic [fcl_pkg::PROD1_W-1:0]  prod1;
  logic [fcl_pkg::SECTOR_W-1:0] sector;
  logic [fcl_pkg::PROD2_W-1:0]  prod2;
  logic [fcl_pkg::OFFSET_W-1:0] offset_reg;
  logic [fcl_pkg::BYTE_W-1:0]   lo_byte;
  logic [fcl_pkg::BYTE_W-1:0]   hi_byte;
  logic [2*fcl_pkg::BYTE_W-1:0] word;
  logic [fcl_pkg::ENTRY_W-1:0]  entry;
  logic                         is_bad;
  logic                         out_valid_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_size       <= fcl_pkg::BPS_RESET;
      cluster_span      <= fcl_pkg::SPC_RESET;
      data_start_sector <= fcl_pkg::DSS_RESET;
      end_marker        <= fcl_pkg::END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fcl_pkg::REG_SECTOR_SIZE:
          sector_size <= cfg_data[fcl_pkg::BPS_W-1:0];
        fcl_pkg::REG_CLUSTER_SPAN:
          cluster_span <= cfg_data[fcl_pkg::SPC_W-1:0];
        fcl_pkg::REG_DATA_START_SECTOR:
          data_start_sector <= cfg_data[fcl_pkg::DSS_W-1:0];
        fcl_pkg::REG_END_MARKER:
          end_marker <= cfg_data[fcl_pkg::ENTRY_W-1:0];
        default: end_marker <= end_marker;
      endcase
    end
  end

  // byte position of the entry: id + id/2
  assign pos_in = fcl_pkg::ADDR_W'(lookup_id) + fcl_pkg::ADDR_W'(lookup_id >> 1);

  // first read at the request, second at the next byte
  assign rd_pos      = cmd.lookup_start ? pos_in : pos_reg + 1'b1;
  assign rd_in_range = {1'b0, rd_pos} < TableLimit;
  assign wr_in_range = {1'b0, table_address} < TableLimit;

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.tbl_write && wr_in_range) begin
      table_mem[table_address[MemAw-1:0]] <= table_byte;
    end
    rd_data <= table_mem[rd_pos[MemAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_in_range;
    end
  end

  // bytes beyond the table read as zero
  assign rd_byte = rd_valid ? rd_data : '0;

  // first multiply at the request
  assign id_m2 = lookup_id - fcl_pkg::FIRST_DATA_ID;

  always_ff @(posedge clk) begin
    if (cmd.lookup_start) begin
      id_reg  <= lookup_id;
      pos_reg <= pos_in;
      prod1   <= fcl_pkg::PROD1_W'(id_m2) * fcl_pkg::PROD1_W'(cluster_span);
    end
  end

  // low byte arrives, add data start
  always_ff @(posedge clk) begin
    if (cmd.lo_capture) begin
      lo_byte <= rd_byte;
      sector  <= fcl_pkg::SECTOR_W'(prod1) + fcl_pkg::SECTOR_W'(data_start_sector);
    end
  end

  // high byte arrives, second multiply
  assign prod2 = fcl_pkg::PROD2_W'(sector) * fcl_pkg::PROD2_W'(sector_size);

  always_ff @(posedge clk) begin
    if (cmd.hi_capture) begin
      hi_byte    <= rd_byte;
      offset_reg <= prod2[fcl_pkg::OFFSET_W-1:0];
    end
  end

  // unpack the 12-bit entry
  assign word   = {hi_byte, lo_byte};
  assign entry  = id_reg[0] ? word[fcl_pkg::ODD_SHIFT +: fcl_pkg::ENTRY_W]
                            : word[fcl_pkg::ENTRY_W-1:0];
  assign is_bad = id_reg < fcl_pkg::FIRST_DATA_ID;

  // output register
  assign status.out_free = !out_valid || !out_stall;
  assign out_valid_next  = cmd.out_load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      next_cluster       <= entry;
      chain_end          <= entry == end_marker;
      bad_cluster        <= is_bad;
      device_byte_offset <= is_bad ? '0 : offset_reg;
    end
  end

endmodule

@@ rtl/fat12_cluster_chain_lookup_top.sv @@
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+----------------------------------------------
// request  | in        | in_valid/in_stall   | kind, table_address, table_byte, lookup_id
// result   | out       | out_valid/out_stall | next_cluster, chain_end, bad_cluster,
//          |           |                     | device_byte_offset
// config   | in        | cfg_we              | cfg_index, cfg_data
//
// a table write leaves the control in ST_IDLE, so the next request is taken right after it
// a lookup goes via ST_READ_LO, ST_READ_HI, ST_RESULT to the result register: two reads on
// the single table read port, with the two offset multiplies registered alongside them
// rst is synchronous; it clears control and configuration, not the table store
// a stalled result waits in the output register; writes and one more lookup are
// still taken, and that lookup holds in_stall high until the register frees
module fat12_cluster_chain_lookup_top #(
  parameter int unsigned TABLE_BYTES = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [fcl_pkg::ADDR_W-1:0]          table_address,
  input  logic [fcl_pkg::BYTE_W-1:0]          table_byte,
  input  logic [fcl_pkg::ID_W-1:0]            lookup_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fcl_pkg::ENTRY_W-1:0]         next_cluster,
  output logic                                chain_end,
  output logic                                bad_cluster,
  output logic [fcl_pkg::OFFSET_W-1:0]        device_byte_offset
);

  fcl_pkg::cmd_t    cmd;
  fcl_pkg::status_t status;

  // sequencing
  fcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // table store and arithmetic
  fcl_datapath #(
    .TABLE_BYTES (TABLE_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .table_address      (table_address),
    .table_byte         (table_byte),
    .lookup_id          (lookup_id),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .next_cluster       (next_cluster),
    .chain_end          (chain_end),
    .bad_cluster        (bad_cluster),
    .device_byte_offset (device_byte_offset)
  );

endmodule
